// ===== src/rlvd_pkg.sv =====
package rlvd_pkg;

  localparam int unsigned WindowBits    = 21;
  localparam int unsigned SymbolBits    = 16;
  localparam int unsigned UsedBits      = 5;
  localparam int unsigned EscPrefixBits = 5;
  localparam int unsigned EscRawBits    = WindowBits - EscPrefixBits;
  localparam int unsigned CfgIndexBits  = 2;
  localparam int unsigned CfgDataBits   = 16;

  localparam logic [EscPrefixBits-1:0] EscPrefixCode = 5'b11000;
  localparam logic [SymbolBits-1:0]    EopCode       = 16'd32;
  localparam logic [SymbolBits-1:0]    EoiCode       = 16'd33;

  localparam logic [4:0]  EscCountReset = 5'd8;
  localparam logic [15:0] EscMaskReset  = 16'd255;

  typedef enum logic [CfgIndexBits-1:0] {
    RegEscCount = 2'd0,
    RegEscMask  = 2'd1
  } reg_index_e;

  typedef struct packed {
    logic [WindowBits-1:0] code_window;
  } rlvd_in_t;

  typedef struct packed {
    logic [SymbolBits-1:0] symbol_value;
    logic [UsedBits-1:0]   bits_used;
    logic                  marker_seen;
    logic                  invalid_code;
  } rlvd_out_t;

  typedef struct packed {
    logic [CfgIndexBits-1:0] index;
    logic [CfgDataBits-1:0]  wdata;
  } rlvd_cfg_t;

  function automatic logic [4:0] sym_len10_five(input logic [1:0] idx);
    logic [4:0] val;
    case (idx)
      2'd0:    val = 5'd16;
      2'd1:    val = 5'd14;
      2'd2:    val = 5'd17;
      default: val = 5'd15;
    endcase
    return val;
  endfunction

  function automatic logic [4:0] sym_len11_six(input logic [2:0] idx);
    logic [4:0] val;
    case (idx)
      3'd0:    val = 5'd30;
      3'd1:    val = 5'd26;
      3'd2:    val = 5'd28;
      3'd3:    val = 5'd24;
      3'd4:    val = 5'd31;
      3'd5:    val = 5'd27;
      3'd6:    val = 5'd29;
      default: val = 5'd25;
    endcase
    return val;
  endfunction

endpackage

// ===== src/rlvd_chan_if.sv =====
interface rlvd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rlvd_decode.sv =====
module rlvd_decode #(
  parameter int unsigned MAX_ESCAPE_BITS = 16
) (
  input  logic [rlvd_pkg::WindowBits-1:0] window_i,
  input  logic [4:0]                      esc_count_i,
  input  logic [15:0]                     esc_mask_i,
  output rlvd_pkg::rlvd_out_t             result_o
);
  import rlvd_pkg::*;

  localparam int unsigned EscCap =
      (MAX_ESCAPE_BITS < EscRawBits) ? MAX_ESCAPE_BITS : EscRawBits;
  localparam logic [4:0] EscCapW = 5'(EscCap);

  logic [4:0]            esc_n;
  logic [EscRawBits:0]   raw_mask_wide;
  logic [EscRawBits-1:0] raw_bits;
  logic [SymbolBits-1:0] esc_value;
  logic [1:0]            r_fld;
  logic [1:0]            s_fld;

  assign esc_n         = (esc_count_i > EscCapW) ? EscCapW : esc_count_i;
  assign raw_mask_wide = ({{EscRawBits{1'b0}}, 1'b1} << esc_n) - 1'b1;
  assign raw_bits      = window_i[WindowBits-1:EscPrefixBits]
                       & raw_mask_wide[EscRawBits-1:0];
  assign esc_value     = SymbolBits'(raw_bits) & esc_mask_i;
  assign r_fld         = window_i[2:1];
  assign s_fld         = window_i[4:3];

  always_comb begin
    result_o = '0;
    if (window_i[0]) begin
      result_o.symbol_value = 16'd0;
      result_o.bits_used    = 5'd1;
    end else if (r_fld == 2'd1) begin
      result_o.symbol_value = 16'd1;
      result_o.bits_used    = 5'd3;
    end else if (r_fld == 2'd2) begin
      result_o.symbol_value = window_i[3] ? 16'd4 : 16'd3;
      result_o.bits_used    = 5'd4;
    end else if (r_fld == 2'd3) begin
      result_o.symbol_value = 16'd2;
      result_o.bits_used    = 5'd3;
    end else if (window_i[EscPrefixBits-1:0] == EscPrefixCode) begin
      result_o.symbol_value = esc_value;
      result_o.bits_used    = 5'(EscPrefixBits) + esc_n;
    end else if (s_fld == 2'd1) begin
      result_o.symbol_value = 16'd5;
      result_o.bits_used    = 5'd5;
    end else if (s_fld == 2'd2) begin
      case (window_i[6:5])
        2'd0: begin
          result_o.symbol_value = window_i[7] ? 16'd11 : 16'd10;
          result_o.bits_used    = 5'd8;
        end
        2'd1: begin
          result_o.symbol_value = 16'd6;
          result_o.bits_used    = 5'd7;
        end
        2'd2: begin
          result_o.symbol_value = window_i[7] ? 16'd9 : 16'd8;
          result_o.bits_used    = 5'd8;
        end
        default: begin
          result_o.symbol_value = 16'd7;
          result_o.bits_used    = 5'd7;
        end
      endcase
    end else begin
      case (window_i[7:5])
        3'd1: begin
          case (window_i[9:8])
            2'd0: begin
              result_o.symbol_value = window_i[10] ? 16'd23 : 16'd22;
              result_o.bits_used    = 5'd11;
            end
            2'd1: begin
              result_o.symbol_value = 16'd18;
              result_o.bits_used    = 5'd10;
            end
            2'd2: begin
              result_o.symbol_value = window_i[10] ? 16'd21 : 16'd20;
              result_o.bits_used    = 5'd11;
            end
            default: begin
              result_o.symbol_value = 16'd19;
              result_o.bits_used    = 5'd10;
            end
          endcase
        end
        3'd2: begin
          if (window_i[10:8] == 3'd3) begin
            result_o.symbol_value = EopCode;
            result_o.bits_used    = 5'd11;
            result_o.marker_seen  = 1'b1;
          end else if (window_i[10:8] == 3'd7) begin
            result_o.symbol_value = EoiCode;
            result_o.bits_used    = 5'd11;
            result_o.marker_seen  = 1'b1;
          end else begin
            result_o.invalid_code = 1'b1;
          end
        end
        3'd3: begin
          result_o.symbol_value = 16'd12;
          result_o.bits_used    = 5'd8;
        end
        3'd5: begin
          result_o.symbol_value = SymbolBits'(sym_len10_five(window_i[9:8]));
          result_o.bits_used    = 5'd10;
        end
        3'd6: begin
          result_o.symbol_value = SymbolBits'(sym_len11_six(window_i[10:8]));
          result_o.bits_used    = 5'd11;
        end
        3'd7: begin
          result_o.symbol_value = 16'd13;
          result_o.bits_used    = 5'd8;
        end
        default: begin
          result_o.invalid_code = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/run_length_vlc_symbol_decoder.sv =====
// Run-length VLC symbol decoder.
// in_i carries a 21-bit window of upcoming stream bits, earliest bit at
// bit 0. Each request yields exactly one result on out_o: the decoded run
// value, marker code or masked escape value, the number of bits consumed,
// and marker / invalid flags. The caller advances its bit reader by
// bits_used.
// cfg_i writes the escape raw-bit count (index 0) and the escape value mask
// (index 1); other indexes are dropped. cfg_i is always ready and should be
// written only while no request is in flight.
// From input request to result valid: one input register, one table decode,
// one result register. Throughput is one request per cycle while out_o does
// not stall.
// When out_o stalls, both stages hold and in_i.ready drops; it returns the
// cycle the result is taken.
// Reset clears both stage valids and loads count 8 and mask 255.
module run_length_vlc_symbol_decoder #(
  parameter int unsigned MAX_ESCAPE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlvd_chan_if.sink   cfg_i,
  rlvd_chan_if.sink   in_i,
  rlvd_chan_if.source out_o
);
  import rlvd_pkg::*;

  logic                  advance;
  logic                  s1_valid_q;
  logic [WindowBits-1:0] window_q;
  logic                  out_valid_q;
  rlvd_out_t             result_d;
  rlvd_out_t             result_q;
  logic [4:0]            esc_count_q;
  logic [15:0]           esc_mask_q;
  rlvd_cfg_t             cfg_req;
  rlvd_in_t              in_req;

  assign cfg_req     = cfg_i.data;
  assign in_req      = in_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_count_q <= EscCountReset;
      esc_mask_q  <= EscMaskReset;
    end else if (cfg_i.valid) begin
      case (cfg_req.index)
        RegEscCount: esc_count_q <= cfg_req.wdata[4:0];
        RegEscMask:  esc_mask_q  <= cfg_req.wdata[15:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_i.valid;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_i.valid) begin
      window_q <= in_req.code_window;
    end
    if (advance && s1_valid_q) begin
      result_q <= result_d;
    end
  end

  rlvd_decode #(
    .MAX_ESCAPE_BITS(MAX_ESCAPE_BITS)
  ) u_decode (
    .window_i   (window_q),
    .esc_count_i(esc_count_q),
    .esc_mask_i (esc_mask_q),
    .result_o   (result_d)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = result_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rlvd_pkg::*;

  localparam int unsigned MaxEscBits    = 16;
  localparam int unsigned PhaseItems    = 170;
  localparam int unsigned LongStall     = 300;
  localparam int unsigned WatchdogLimit = 3000;

  // indexes outside the register map, writes must be dropped
  localparam logic [CfgIndexBits-1:0] RegUnusedA = 2'd2;
  localparam logic [CfgIndexBits-1:0] RegUnusedB = 2'd3;

  logic clk_i;
  logic rst_ni;

  rlvd_chan_if #(.payload_t(rlvd_cfg_t)) cfg_if ();
  rlvd_chan_if #(.payload_t(rlvd_in_t))  in_if ();
  rlvd_chan_if #(.payload_t(rlvd_out_t)) out_if ();

  run_length_vlc_symbol_decoder #(
    .MAX_ESCAPE_BITS(MaxEscBits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [WindowBits-1:0] pending_windows[$];
  rlvd_out_t             expected_symbols[$];

  logic [4:0]  esc_count_q = EscCountReset;
  logic [15:0] esc_mask_q  = EscMaskReset;

  logic        in_fire = 1'b0;
  bit          idle_on = 1'b1;
  bit          src_hold = 1'b0;
  bit          long_stall_go = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic rlvd_out_t decode_symbol(input logic [WindowBits-1:0] w,
                                              input logic [4:0] esc_count,
                                              input logic [15:0] esc_mask);
    rlvd_out_t   res;
    int unsigned n;
    logic [31:0] raw;
    res = '0;
    if (w[0]) begin
      res.bits_used = 5'd1;
    end else if (w[2:1] == 2'd1) begin
      res.symbol_value = 16'd1;
      res.bits_used    = 5'd3;
    end else if (w[2:1] == 2'd2) begin
      res.symbol_value = w[3] ? 16'd4 : 16'd3;
      res.bits_used    = 5'd4;
    end else if (w[2:1] == 2'd3) begin
      res.symbol_value = 16'd2;
      res.bits_used    = 5'd3;
    end else if (w[4:3] == 2'd3) begin
      // escape: raw bits after the prefix, count saturated
      n = esc_count;
      if (n > MaxEscBits) n = MaxEscBits;
      if (n > EscRawBits) n = EscRawBits;
      raw = (32'(w) >> EscPrefixBits) & ((32'd1 << n) - 32'd1);
      res.symbol_value = raw[15:0] & esc_mask;
      res.bits_used    = 5'(EscPrefixBits + n);
    end else if (w[4:3] == 2'd1) begin
      res.symbol_value = 16'd5;
      res.bits_used    = 5'd5;
    end else if (w[4:3] == 2'd2) begin
      case (w[6:5])
        2'd0: begin
          res.symbol_value = w[7] ? 16'd11 : 16'd10;
          res.bits_used    = 5'd8;
        end
        2'd1: begin
          res.symbol_value = 16'd6;
          res.bits_used    = 5'd7;
        end
        2'd2: begin
          res.symbol_value = w[7] ? 16'd9 : 16'd8;
          res.bits_used    = 5'd8;
        end
        default: begin
          res.symbol_value = 16'd7;
          res.bits_used    = 5'd7;
        end
      endcase
    end else begin
      case (w[7:5])
        3'd1: begin
          case (w[9:8])
            2'd0: begin
              res.symbol_value = w[10] ? 16'd23 : 16'd22;
              res.bits_used    = 5'd11;
            end
            2'd1: begin
              res.symbol_value = 16'd18;
              res.bits_used    = 5'd10;
            end
            2'd2: begin
              res.symbol_value = w[10] ? 16'd21 : 16'd20;
              res.bits_used    = 5'd11;
            end
            default: begin
              res.symbol_value = 16'd19;
              res.bits_used    = 5'd10;
            end
          endcase
        end
        3'd2: begin
          if (w[10:8] == 3'd3) begin
            res.symbol_value = EopCode;
            res.bits_used    = 5'd11;
            res.marker_seen  = 1'b1;
          end else if (w[10:8] == 3'd7) begin
            res.symbol_value = EoiCode;
            res.bits_used    = 5'd11;
            res.marker_seen  = 1'b1;
          end else begin
            res.invalid_code = 1'b1;
          end
        end
        3'd3: begin
          res.symbol_value = 16'd12;
          res.bits_used    = 5'd8;
        end
        3'd5: begin
          case (w[9:8])
            2'd0:    res.symbol_value = 16'd16;
            2'd1:    res.symbol_value = 16'd14;
            2'd2:    res.symbol_value = 16'd17;
            default: res.symbol_value = 16'd15;
          endcase
          res.bits_used = 5'd10;
        end
        3'd6: begin
          case (w[10:8])
            3'd0:    res.symbol_value = 16'd30;
            3'd1:    res.symbol_value = 16'd26;
            3'd2:    res.symbol_value = 16'd28;
            3'd3:    res.symbol_value = 16'd24;
            3'd4:    res.symbol_value = 16'd31;
            3'd5:    res.symbol_value = 16'd27;
            3'd6:    res.symbol_value = 16'd29;
            default: res.symbol_value = 16'd25;
          endcase
          res.bits_used = 5'd11;
        end
        3'd7: begin
          res.symbol_value = 16'd13;
          res.bits_used    = 5'd8;
        end
        default: begin
          res.invalid_code = 1'b1;
        end
      endcase
    end
    return res;
  endfunction

  // random window steered toward one code class, filler bits random
  function automatic logic [WindowBits-1:0] random_window();
    logic [WindowBits-1:0] w;
    w = WindowBits'($urandom);
    case ($urandom_range(0, 9))
      0, 1: ;
      2: w[4:0] = EscPrefixCode;
      3: w[4:0] = 5'b01000;
      4: w[4:0] = 5'b10000;
      5, 6, 7, 8: w[4:0] = 5'b00000;
      default: begin
        w[7:0]  = 8'b0100_0000;
        w[10:8] = ($urandom_range(0, 1) != 0) ? 3'd3 : 3'd7;
      end
    endcase
    return w;
  endfunction

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_windows.size() != 0 || in_if.valid || expected_symbols.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && !in_fire) begin
        // hold the offered request
      end else if (src_gap > 0) begin
        src_gap = src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_windows.size() != 0 && !src_hold) begin
        in_if.valid <= 1'b1;
        in_if.data  <= '{code_window: pending_windows.pop_front()};
        if (idle_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_stall_go) begin
        long_stall_go = 1'b0;
        sink_stall = LongStall;
      end
      if (sink_stall > 0) begin
        sink_stall = sink_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) sink_stall = $urandom_range(1, 17);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    rlvd_out_t exp_sym;
    if (rst_ni) begin
      in_fire <= in_if.valid && in_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          RegEscCount: esc_count_q <= cfg_if.data.wdata[4:0];
          RegEscMask:  esc_mask_q  <= cfg_if.data.wdata;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        expected_symbols.push_back(decode_symbol(in_if.data.code_window, esc_count_q,
                                                 esc_mask_q));
      if (out_if.valid && out_if.ready) begin
        if (expected_symbols.size() == 0) begin
          error_count++;
          $error("unexpected result: symbol_value %0d", out_if.data.symbol_value);
        end else begin
          exp_sym = expected_symbols.pop_front();
          if (out_if.data.symbol_value !== exp_sym.symbol_value) begin
            error_count++;
            $error("symbol_value: expected %0d, got %0d", exp_sym.symbol_value,
                   out_if.data.symbol_value);
          end
          if (out_if.data.bits_used !== exp_sym.bits_used) begin
            error_count++;
            $error("bits_used: expected %0d, got %0d", exp_sym.bits_used,
                   out_if.data.bits_used);
          end
          if (out_if.data.marker_seen !== exp_sym.marker_seen) begin
            error_count++;
            $error("marker_seen: expected %0d, got %0d", exp_sym.marker_seen,
                   out_if.data.marker_seen);
          end
          if (out_if.data.invalid_code !== exp_sym.invalid_code) begin
            error_count++;
            $error("invalid_code: expected %0d, got %0d", exp_sym.invalid_code,
                   out_if.data.invalid_code);
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
          $error("watchdog: no request moved for %0d cycles", quiet_cycles);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned i;
    logic [4:0]  cnt;
    logic [15:0] msk;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every code class at the reset escape settings
    pending_windows = '{
      21'h1FFFFF, 21'h000000, 21'h000002, 21'h000004, 21'h00000C, 21'h000006,
      21'h1FFFF8, 21'h000018, 21'h000008, 21'h000010, 21'h000090, 21'h000030,
      21'h000050, 21'h0000D0, 21'h000070, 21'h000020, 21'h000420, 21'h000120,
      21'h000220, 21'h000320, 21'h000340, 21'h000740, 21'h000040, 21'h000060,
      21'h000080, 21'h0001A0, 21'h0007C0, 21'h0000E0
    };
    wait_drained();
    write_reg(RegUnusedA, 16'hFFFF);
    write_reg(RegUnusedB, 16'h0001);

    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin cnt = 5'd0;  msk = 16'hFFFF; end
        1: begin cnt = 5'd16; msk = 16'hFFFF; end
        2: begin cnt = 5'd31; msk = 16'h0000; end
        3: begin cnt = 5'd17; msk = 16'($urandom); end
        4: begin cnt = 5'd1;  msk = 16'h0001; end
        default: begin
          cnt = 5'($urandom);
          msk = 16'($urandom);
        end
      endcase
      write_reg(RegEscCount, {11'($urandom), cnt});
      write_reg(RegEscMask, msk);
      idle_on = (ph == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        pending_windows.push_back(21'h1FFFF8);
        pending_windows.push_back(21'h000018);
      end
      for (i = 0; i < PhaseItems; i++) pending_windows.push_back(random_window());
      if (ph == 1) begin
        // fill the pipe behind a long receiver stall, then drain fully mid-phase
        long_stall_go = 1'b1;
        while (pending_windows.size() > PhaseItems / 2) @(posedge clk_i);
        src_hold = 1'b1;
        while (in_if.valid || expected_symbols.size() != 0) @(posedge clk_i);
        repeat (5) @(posedge clk_i);
        src_hold = 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (expected_symbols.size() != 0) begin
      error_count++;
      $error("%0d results never arrived", expected_symbols.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
